// ===== rtl/core/owts_pkg.sv =====
// Package with the shared types, constants and the CRC-8 byte function of the scratchpad decoder.
package owts_pkg;

   localparam int unsigned SCRATCH_LEN = 9;
   localparam int unsigned COUNT_W     = $clog2(SCRATCH_LEN + 1);

   typedef logic [COUNT_W-1:0] count_type;

   // Byte positions inside the scratchpad that the decoder uses.
   localparam count_type IDX_TEMP_LSB = COUNT_W'(0);
   localparam count_type IDX_TEMP_MSB = COUNT_W'(1);
   localparam count_type IDX_CONFIG   = COUNT_W'(4);
   localparam count_type IDX_REMAIN   = COUNT_W'(6);
   localparam count_type IDX_LAST     = COUNT_W'(SCRATCH_LEN - 1);

   localparam logic [7:0] CRC_POLY = 8'h8C;

   localparam logic [15:0] S_EVEN_MASK  = 16'hfffe;
   localparam logic [15:0] S_OFFSET     = 16'd12;  // 16 minus the quarter-degree bias of 4
   localparam logic [15:0] CENTI_PER_DEG = 16'd100;
   localparam logic [6:0]  FRAC_HALF    = 7'd50;
   localparam logic [6:0]  FRAC_QUARTER = 7'd25;
   localparam logic [6:0]  FRAC_EIGHTH  = 7'd13;
   localparam logic [6:0]  FRAC_16TH    = 7'd6;

   // Resolution codes from bits 6:5 of the configuration byte.
   localparam logic [1:0] RES_12BIT = 2'b11;
   localparam logic [1:0] RES_11BIT = 2'b10;
   localparam logic [1:0] RES_10BIT = 2'b01;

   typedef enum logic [1:0] {
      KIND_B     = 2'd0,
      KIND_S     = 2'd1,
      KIND_OTHER = 2'd2
   } kind_type;

   typedef logic signed [14:0] centi_type;

   // One finished read handed from the front end to the back end.
   typedef struct packed {
      logic [15:0] raw_temp;
      logic [1:0]  res_bits;
      logic [7:0]  count_remain;
      logic        failed;
      kind_type    kind;
   } job_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/core/owts_if.sv =====
// Handshake interfaces for the request, response and control-register channels.
interface owts_req_if;
   import owts_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] scratch_byte;
   logic       start_of_read;
   modport source (output valid, output scratch_byte, output start_of_read, input ready);
   modport sink   (input valid, input scratch_byte, input start_of_read, output ready);
endinterface

interface owts_rsp_if;
   import owts_pkg::*;
   logic      valid;
   logic      ready;
   centi_type temperature_centi;
   logic      read_failed;
   modport source (output valid, output temperature_centi, output read_failed, input ready);
   modport sink   (input valid, input temperature_centi, input read_failed, output ready);
endinterface

interface owts_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/owts_front.sv =====
// Front end: byte counting, CRC-8, nonzero tracking and capture of the bytes the decode needs.
module owts_front (
   input  logic             clock,
   input  logic             reset,
   owts_req_if.sink         req_chan,
   owts_csr_if.sink         csr_chan,
   input  logic             queue_full,
   output logic             push,
   output owts_pkg::job_type push_job
);
   import owts_pkg::*;

   count_type  count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic       nz_ff, nz_in;
   logic [1:0] kind_ff;
   logic [7:0] lsb_ff, msb_ff, remain_ff;
   logic [1:0] res_ff;

   count_type  idx;
   logic [7:0] crc_base, crc_new;
   logic       nz_base, nz_new, accept, last;

   assign req_chan.ready = !queue_full;
   assign csr_chan.ready = 1'b1;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      idx      = (req_chan.start_of_read || count_ff > IDX_LAST) ? '0 : count_ff;
      crc_base = req_chan.start_of_read ? 8'h00 : crc_ff;
      nz_base  = req_chan.start_of_read ? 1'b0 : nz_ff;
      crc_new  = crc8_byte(crc_base, req_chan.scratch_byte);
      nz_new   = nz_base || (req_chan.scratch_byte != 8'h00);
      last     = (idx == IDX_LAST);
      count_in = count_ff;
      crc_in   = crc_ff;
      nz_in    = nz_ff;
      if (accept) begin
         if (last) begin
            count_in = '0;
            crc_in   = 8'h00;
            nz_in    = 1'b0;
         end else begin
            count_in = idx + COUNT_W'(1);
            crc_in   = crc_new;
            nz_in    = nz_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff   <= 8'h00;
         nz_ff    <= 1'b0;
         kind_ff  <= KIND_B;
      end else begin
         count_ff <= count_in;
         crc_ff   <= crc_in;
         nz_ff    <= nz_in;
         if (csr_chan.valid) begin
            kind_ff <= csr_chan.data;
         end
      end
   end

   // Only the temperature, configuration and count-remain bytes are kept.
   always_ff @(posedge clock) begin
      if (accept) begin
         case (idx)
            IDX_TEMP_LSB: lsb_ff    <= req_chan.scratch_byte;
            IDX_TEMP_MSB: msb_ff    <= req_chan.scratch_byte;
            IDX_CONFIG:   res_ff    <= req_chan.scratch_byte[6:5];
            IDX_REMAIN:   remain_ff <= req_chan.scratch_byte;
            default: ;
         endcase
      end
   end

   always_comb begin
      push                  = accept && last;
      push_job.raw_temp     = {msb_ff, lsb_ff};
      push_job.res_bits     = res_ff;
      push_job.count_remain = remain_ff;
      push_job.failed       = (crc_new != 8'h00) || !nz_new;
      case (kind_ff)
         KIND_B:  push_job.kind = KIND_B;
         KIND_S:  push_job.kind = KIND_S;
         default: push_job.kind = KIND_OTHER;
      endcase
   end

endmodule

// ===== rtl/core/owts_queue.sv =====
// Two-entry queue of finished reads between the front end and the back end.
module owts_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  owts_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output owts_pkg::job_type head_job
);
   import owts_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head_job  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/owts_back.sv =====
// Back end: precision adjustment, conversion to hundredths of a degree and the result register.
module owts_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              not_empty,
   input  owts_pkg::job_type head_job,
   output logic              pop,
   owts_rsp_if.source        rsp_chan
);
   import owts_pkg::*;

   logic        valid_ff, valid_in;
   centi_type   temp_ff, temp_in;
   logic        failed_ff;
   logic [15:0] adj;
   logic [15:0] whole_ext, prod;
   logic [6:0]  frac_add;

   assign pop                        = not_empty && (!valid_ff || rsp_chan.ready);
   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.temperature_centi = temp_ff;
   assign rsp_chan.read_failed       = failed_ff;

   always_comb begin
      case (head_job.kind)
         KIND_S: begin
            adj = ((head_job.raw_temp & S_EVEN_MASK) << 3) + S_OFFSET
                  - {8'h00, head_job.count_remain};
         end
         KIND_B: begin
            case (head_job.res_bits)
               RES_12BIT: adj = head_job.raw_temp;
               RES_11BIT: adj = head_job.raw_temp & ~16'h0001;
               RES_10BIT: adj = head_job.raw_temp & ~16'h0003;
               default:   adj = head_job.raw_temp & ~16'h0007;
            endcase
         end
         default: adj = head_job.raw_temp;
      endcase

      whole_ext = {{8{adj[11]}}, adj[11:4]};
      prod      = whole_ext * CENTI_PER_DEG;
      frac_add  = (adj[3] ? FRAC_HALF : 7'd0) + (adj[2] ? FRAC_QUARTER : 7'd0)
                + (adj[1] ? FRAC_EIGHTH : 7'd0) + (adj[0] ? FRAC_16TH : 7'd0);
      temp_in   = head_job.failed ? '0 : centi_type'(prod[14:0] + {8'h00, frac_add});
      valid_in  = pop ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         temp_ff   <= temp_in;
         failed_ff <= head_job.failed;
      end
   end

endmodule

// ===== rtl/core/onewire_temp_scratchpad_decode.sv =====
// Top level of the one-wire temperature sensor scratchpad decoder.
//
//   Channel    Direction  Moves per transaction
//   req_chan   in         one scratchpad byte and its start-of-read mark
//   rsp_chan   out        temperature in hundredths of a degree and failure flag
//   csr_chan   in         sensor kind (0 B-type, 1 S-type, 2 or 3 no adjustment)
//
// One byte is taken in every cycle while the queue is not full; the byte
// counter, the CRC-8 and the nonzero flag are updated in the same cycle the
// byte is accepted. The ninth byte of a read puts one job into a two-entry
// queue; the back end pops it when the result register is free or being taken
// and registers the result. Reset clears the counter, CRC, flag, queue and
// result valid and selects the B-type sensor. A stalled response holds its
// register and the queue keeps accepting bytes until both entries are full.
module onewire_temp_scratchpad_decode (
   input logic        clock,
   input logic        reset,
   owts_req_if.sink   req_chan,
   owts_rsp_if.source rsp_chan,
   owts_csr_if.sink   csr_chan
);
   import owts_pkg::*;

   // Front end and back end meet only through the queue.
   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    queue_not_empty;
   logic    pop;
   job_type head_job;

   owts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   owts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_job  (head_job)
   );

   owts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
